// ----- rtl/core/plti_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plti_pkg
// Shared types and constants of the interpolation lookup table.
// ----------------------------------------------------------------------------
package plti_pkg;

  localparam int unsigned QW = 32;
  localparam int unsigned PW = 64;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_ZERO = 2'd1;
  localparam logic [1:0] STATUS_SAT  = 2'd2;

  localparam logic ACTION_LOAD  = 1'b0;
  localparam logic ACTION_QUERY = 1'b1;

  typedef struct packed {
    logic        load;
    logic        hit;
    logic [QW-1:0] time_v;
    logic [QW-1:0] value_v;
  } cell_cmd_t;

endpackage

// ----- rtl/core/plti_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plti_cell
// One breakpoint cell: holds a time and a value and reports them on its outputs.
// ----------------------------------------------------------------------------
module plti_cell
  import plti_pkg::*;
(
  input  logic          clk,
  input  logic          wr_en,
  input  logic [QW-1:0] wr_time,
  input  logic [QW-1:0] wr_value,
  output logic [QW-1:0] time_o,
  output logic [QW-1:0] value_o
);

  logic [QW-1:0] time_r;
  logic [QW-1:0] value_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_r  <= wr_time;
      value_r <= wr_value;
    end
  end

  assign time_o  = time_r;
  assign value_o = value_r;

endmodule

// ----- rtl/core/plti_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plti_div
// Restoring divider, one quotient bit per cycle, 64 by 32 bits.
// ----------------------------------------------------------------------------
module plti_div
  import plti_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [PW-1:0] dividend,
  input  logic [QW-1:0] divisor,
  output logic          done,
  output logic [PW-1:0] quotient
);

  logic [PW-1:0] quo_r, quo_nxt;
  logic [QW:0]   rem_r, rem_nxt;
  logic [QW-1:0] dsr_r, dsr_nxt;
  logic [6:0]    cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [QW:0]   trial;
  logic [QW+1:0] diff;

  always_comb begin
    trial    = {rem_r[QW-1:0], quo_r[PW-1]};
    diff     = {1'b0, trial} - {2'b00, dsr_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = 7'(PW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[QW+1]) begin
        rem_nxt = diff[QW:0];
        quo_nxt = {quo_r[PW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[PW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- rtl/core/piecewise_linear_table_interp_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp_top
// Piecewise-linear interpolation over a table of Q16.16 breakpoints.
// ----------------------------------------------------------------------------
// A load transfer writes one breakpoint cell. A query transfer first rotates
// the row of cells through a scan port, one breakpoint per cycle, through the
// whole row. A 32 by 32 multiply then feeds a bit-serial 64 by 32 divider.
// A zero-width segment skips waiting for the division. A query time of zero
// still runs the full scan and division. The block holds one query at a time
// and takes the next item in the cycle after the result transfer.
module piecewise_linear_table_interp_top
  import plti_pkg::*;
#(
  parameter int MAX_POINTS = 64
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [5:0]  in_entry_index,
  input  logic signed [31:0] in_entry_time,
  input  logic signed [31:0] in_entry_value,
  input  logic signed [31:0] in_query_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_result_value,
  output logic [5:0]  out_segment_start,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = IW + 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]    st_r, st_nxt;
  logic [6:0]    pts_r;
  logic [CW-1:0] n_eff;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          found_r, found_nxt;
  logic [QW-1:0] q_r, t0_r, t1_r, v0_r, v1_r;
  logic [QW-1:0] t0_nxt, t1_nxt, v0_nxt, v1_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [QW-1:0] prev_t_r, prev_v_r;
  logic          neg_r;
  logic [QW:0]   mdv_r, mdt_r, mdd_r;
  logic [PW-1:0] prod;
  logic [QW-1:0] res_r;
  logic [5:0]    seg_r;
  logic [1:0]    stat_r;
  logic          div_start, div_done;
  logic [PW-1:0] div_q;

  // Row of cells: the scan rotates the row so cell 0 always presents the next
  // breakpoint. A scan makes exactly MAX_POINTS steps, so the row is back in
  // place when the block is idle.
  logic [QW-1:0] c_t [MAX_POINTS];
  logic [QW-1:0] c_v [MAX_POINTS];
  logic [QW-1:0] w_t [MAX_POINTS];
  logic [QW-1:0] w_v [MAX_POINTS];
  logic          w_en [MAX_POINTS];
  logic          rotate;
  logic          in_xfer;

  assign in_xfer   = in_valid && !in_stall;
  assign in_stall  = (st_r != ST_IDLE);
  assign cfg_ready = (st_r == ST_IDLE) && !in_valid;
  assign rotate    = (st_r == ST_SCAN);

  genvar g;
  generate
    for (g = 0; g < MAX_POINTS; g++) begin : g_cell
      always_comb begin
        if (rotate) begin
          w_en[g] = 1'b1;
          w_t[g]  = c_t[(g + 1) % MAX_POINTS];
          w_v[g]  = c_v[(g + 1) % MAX_POINTS];
        end else begin
          w_en[g] = in_xfer && (in_action == ACTION_LOAD) &&
                    (32'(in_entry_index) == 32'(g));
          w_t[g]  = in_entry_time;
          w_v[g]  = in_entry_value;
        end
      end
      plti_cell u_cell (
        .clk     (clk),
        .wr_en   (w_en[g]),
        .wr_time (w_t[g]),
        .wr_value(w_v[g]),
        .time_o  (c_t[g]),
        .value_o (c_v[g])
      );
    end
  endgenerate

  always_comb begin
    if (pts_r < 7'd2) begin
      n_eff = CW'(2);
    end else if ({25'd0, pts_r} > MAX_POINTS) begin
      n_eff = CW'(MAX_POINTS);
    end else begin
      n_eff = CW'(pts_r);
    end
  end

  logic signed [QW:0] dv_s, dt_s, dd_s;
  logic [QW:0] mdv, mdt, mdd;
  always_comb begin
    dv_s = $signed({v1_r[QW-1], v1_r}) - $signed({v0_r[QW-1], v0_r});
    dt_s = $signed({q_r[QW-1], q_r}) - $signed({t0_r[QW-1], t0_r});
    dd_s = $signed({t1_r[QW-1], t1_r}) - $signed({t0_r[QW-1], t0_r});
    mdv  = dv_s[QW] ? -dv_s : dv_s;
    mdt  = dt_s[QW] ? -dt_s : dt_s;
    mdd  = dd_s[QW] ? -dd_s : dd_s;
    prod = PW'(mdv[QW-1:0]) * PW'(mdt[QW-1:0]);
  end

  always_comb begin
    st_nxt    = st_r;
    idx_nxt   = idx_r;
    found_nxt = found_r;
    k_nxt     = k_r;
    t0_nxt    = t0_r;
    t1_nxt    = t1_r;
    v0_nxt    = v0_r;
    v1_nxt    = v1_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_xfer && in_action == ACTION_QUERY) begin
          st_nxt    = ST_SCAN;
          idx_nxt   = '0;
          found_nxt = 1'b0;
        end
      end
      ST_SCAN: begin
        if (idx_r != '0 && !found_r && idx_r < n_eff) begin
          if ($signed(q_r) <= $signed(c_t[0]) || idx_r == n_eff - CW'(1)) begin
            found_nxt = 1'b1;
            k_nxt     = idx_r;
            t0_nxt    = prev_t_r;
            v0_nxt    = prev_v_r;
            t1_nxt    = c_t[0];
            v1_nxt    = c_v[0];
          end
        end
        idx_nxt = idx_r + CW'(1);
        if (idx_r == CW'(MAX_POINTS - 1)) begin
          st_nxt = ST_MUL;
        end
      end
      ST_MUL: st_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done || mdd_r == '0) begin
          st_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign div_start = (st_r == ST_MUL);

  plti_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(prod),
    .divisor (mdd[QW-1:0]),
    .done    (div_done),
    .quotient(div_q)
  );

  logic signed [QW+1:0] sum_s;
  logic [PW-1:0] quo_eff;
  always_comb begin
    quo_eff = (mdv_r == '0 || mdt_r == '0) ? '0 : div_q;
    sum_s   = neg_r ? $signed({v0_r[QW-1], v0_r[QW-1], v0_r}) -
                      $signed({2'b00, quo_eff[QW-1:0]})
                    : $signed({v0_r[QW-1], v0_r[QW-1], v0_r}) +
                      $signed({2'b00, quo_eff[QW-1:0]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      pts_r <= 7'd2;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid && cfg_ready) begin
        pts_r <= cfg_data;
      end
    end
    idx_r    <= idx_nxt;
    found_r  <= found_nxt;
    k_r      <= k_nxt;
    t0_r     <= t0_nxt;
    t1_r     <= t1_nxt;
    v0_r     <= v0_nxt;
    v1_r     <= v1_nxt;
    prev_t_r <= c_t[0];
    prev_v_r <= c_v[0];
    if (in_xfer) begin
      q_r <= in_query_time;
    end
    if (st_r == ST_MUL) begin
      mdv_r <= mdv;
      mdt_r <= mdt;
      mdd_r <= mdd;
      neg_r <= (dv_s[QW] != dt_s[QW]) != dd_s[QW];
    end
    if (st_r == ST_DIV && st_nxt == ST_OUT) begin
      seg_r <= (q_r == '0) ? 6'd0 : 6'(k_r - CW'(1));
      if (q_r == '0) begin
        res_r  <= c_v[0];
        stat_r <= STATUS_OK;
      end else if (mdd_r == '0) begin
        res_r  <= v0_r;
        stat_r <= STATUS_ZERO;
      end else if (quo_eff[PW-1:QW] != '0) begin
        res_r  <= neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
        stat_r <= STATUS_SAT;
      end else if (sum_s > $signed(34'sh0_7FFF_FFFF)) begin
        res_r  <= 32'h7FFF_FFFF;
        stat_r <= STATUS_SAT;
      end else if (sum_s < -$signed(34'sh0_8000_0000)) begin
        res_r  <= 32'h8000_0000;
        stat_r <= STATUS_SAT;
      end else begin
        res_r  <= sum_s[QW-1:0];
        stat_r <= STATUS_OK;
      end
    end
  end

  assign out_valid         = (st_r == ST_OUT);
  assign out_result_value  = res_r;
  assign out_segment_start = seg_r;
  assign out_status        = stat_r;

endmodule

// ----- verif/plti_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plti_checker
// Watches the query, result and register channels of the interpolation table.
// It keeps its own copy of the breakpoints and the point count and works out
// every query's result. Each result transfer is compared field by field with
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module plti_checker
  import plti_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_action,
  input  logic [5:0]         in_entry_index,
  input  logic signed [31:0] in_entry_time,
  input  logic signed [31:0] in_entry_value,
  input  logic signed [31:0] in_query_time,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_result_value,
  input  logic [5:0]         out_segment_start,
  input  logic [1:0]         out_status,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [6:0]         cfg_data,
  output int                 pending,
  output int                 fails
);

  typedef struct packed {
    logic signed [31:0] value;
    logic [5:0]         seg;
    logic [1:0]         status;
  } interp_result_t;

  logic signed [31:0] bp_time [64];
  logic signed [31:0] bp_value [64];
  logic [6:0]         point_count;
  interp_result_t     awaited_results [$];

  function automatic logic [63:0] magnitude(input longint x);
    return (x < 0) ? 64'(-x) : 64'(x);
  endfunction

  function automatic interp_result_t interpolate(input logic signed [31:0] qt);
    interp_result_t r;
    int             n;
    int             k;
    longint         t0, t1, v0, v1, dd, dv, dt, res;
    logic [63:0]    prod, quo;
    logic           neg;
    bit             found;
    n = (point_count < 2) ? 2 : (point_count > 64) ? 64 : int'(point_count);
    r.status = STATUS_OK;
    if (qt == 0) begin
      r.value = bp_value[0];
      r.seg = 6'd0;
      return r;
    end
    k = n - 1;
    found = 0;
    for (int i = 1; i < n; i++) begin
      if (!found && qt <= bp_time[i]) begin
        k = i;
        found = 1;
      end
    end
    t0 = bp_time[k-1];
    t1 = bp_time[k];
    v0 = bp_value[k-1];
    v1 = bp_value[k];
    dd = t1 - t0;
    if (dd == 0) begin
      res = v0;
      r.status = STATUS_ZERO;
    end else begin
      dv = v1 - v0;
      dt = longint'(qt) - t0;
      neg = ((dv < 0) != (dt < 0)) != (dd < 0);
      prod = magnitude(dv) * magnitude(dt);
      quo = prod / magnitude(dd);
      if (dv == 0 || dt == 0) quo = 0;
      if (quo > 64'h2_0000_0000) begin
        res = neg ? -64'sd2147483648 : 64'sd2147483647;
        r.status = STATUS_SAT;
      end else begin
        res = v0 + (neg ? -longint'(quo) : longint'(quo));
        if (res > 64'sd2147483647) begin
          res = 64'sd2147483647;
          r.status = STATUS_SAT;
        end else if (res < -64'sd2147483648) begin
          res = -64'sd2147483648;
          r.status = STATUS_SAT;
        end
      end
    end
    r.value = res[31:0];
    r.seg = 6'(k - 1);
    return r;
  endfunction

  always @(posedge clk) begin
    interp_result_t exp_r;
    int             delta;
    delta = 0;
    if (!rst_n) begin
      point_count <= 7'd2;
      pending <= 0;
      fails <= 0;
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        point_count <= cfg_data;
      end
      if (in_valid && !in_stall) begin
        if (in_action == ACTION_LOAD) begin
          bp_time[in_entry_index] <= in_entry_time;
          bp_value[in_entry_index] <= in_entry_value;
        end else begin
          awaited_results.push_back(interpolate(in_query_time));
          delta++;
        end
      end
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result transfer with nothing expected, got value %h seg %0d status %0d",
                   $time, out_result_value, out_segment_start, out_status);
          fails <= fails + 1;
        end else begin
          exp_r = awaited_results.pop_front();
          delta--;
          if (exp_r.value !== out_result_value || exp_r.seg !== out_segment_start ||
              exp_r.status !== out_status) begin
            $display("%0t: mismatch, expected value %h seg %0d status %0d, got value %h seg %0d status %0d",
                     $time, exp_r.value, exp_r.seg, exp_r.status,
                     out_result_value, out_segment_start, out_status);
            fails <= fails + 1;
          end
        end
      end
      pending <= pending + delta;
    end
  end

endmodule

// ----- verif/tb_piecewise_linear_table_interp_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_piecewise_linear_table_interp_top
// Stimulus and verdict for the interpolation lookup table.
// ----------------------------------------------------------------------------
// The table is filled completely before the first query, so no query ever
// reads an unwritten breakpoint. A directed part covers the corners, then
// phases with different point counts run mostly ascending tables with random
// queries, mixed with unordered loads. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_piecewise_linear_table_interp_top;
  import plti_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_action;
  logic [5:0]         in_entry_index;
  logic signed [31:0] in_entry_time;
  logic signed [31:0] in_entry_value;
  logic signed [31:0] in_query_time;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_result_value;
  logic [5:0]         out_segment_start;
  logic [1:0]         out_status;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [6:0]         cfg_data;
  int                 pending;
  int                 fails;
  int                 cycles;
  bit                 quiet;
  int                 stall_left;
  logic signed [31:0] table_times [64];

  piecewise_linear_table_interp_top dut (.*);
  plti_checker u_checker (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(99) < 3) begin
      stall_left <= $urandom_range(60, 15);
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < 30);
    end
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic send(input logic act, input logic [5:0] idx, input logic [31:0] et,
                      input logic [31:0] ev, input logic [31:0] qt);
    logic st;
    int   g;
    in_valid <= 1'b1;
    in_action <= act;
    in_entry_index <= idx;
    in_entry_time <= et;
    in_entry_value <= ev;
    in_query_time <= qt;
    do begin
      @(negedge clk);
      st = in_stall;
      @(posedge clk);
    end while (st);
    g = idle_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic load_entry(input int idx, input logic [31:0] t, input logic [31:0] v);
    table_times[idx] = t;
    send(ACTION_LOAD, 6'(idx), t, v, $urandom);
  endtask

  task automatic query(input logic [31:0] qt);
    send(ACTION_QUERY, 6'($urandom), $urandom, $urandom, qt);
  endtask

  task automatic write_point_count(input logic [6:0] v);
    logic r;
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (200) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do begin
      @(negedge clk);
      r = cfg_ready;
      @(posedge clk);
    end while (!r);
    cfg_valid <= 1'b0;
  endtask

  task automatic fill_ascending();
    int q[$];
    int mode;
    int base;
    mode = $urandom_range(2);
    base = $urandom;
    for (int i = 0; i < 64; i++) begin
      case (mode)
        0: q.push_back($urandom);
        1: q.push_back(base + $urandom_range(1000));
        default: q.push_back(base + i * $urandom_range(1 << 20, 1));
      endcase
    end
    if (mode != 2) q.sort();
    for (int i = 0; i < 64; i++) begin
      load_entry(i, q[i], ($urandom_range(3) == 0) ? $urandom : $urandom_range(1 << 20));
    end
  endtask

  function automatic logic [31:0] pick_query_time(input int n);
    int k;
    k = $urandom_range(n - 1);
    case ($urandom_range(9))
      0: return 32'd0;
      1: return table_times[k];
      2: return table_times[k] + $urandom_range(8) - 4;
      3: return 32'h7fff_ffff;
      4: return 32'h8000_0000;
      5, 6: return $urandom;
      default: begin
        if (k < n - 1 && table_times[k+1] > table_times[k]) begin
          return table_times[k] + $urandom_range(table_times[k+1] - table_times[k]);
        end
        return table_times[k] + $urandom_range(100);
      end
    endcase
  endfunction

  initial begin
    int count_choices[8];
    int n;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_action <= ACTION_LOAD;
    in_entry_index <= '0;
    in_entry_time <= '0;
    in_entry_value <= '0;
    in_query_time <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    quiet = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Evenly spaced table with extreme values at both ends.
    for (int i = 0; i < 64; i++) begin
      load_entry(i, (i - 32) * (1 << 20), (i == 0) ? 32'h8000_0000 :
                 (i == 63) ? 32'h7fff_ffff : i * 32'h0001_2345);
    end
    write_point_count(7'd64);
    query(32'd0);
    query(32'h8000_0000);
    query(32'h7fff_ffff);
    query(table_times[0]);
    query(table_times[1]);
    query(table_times[63]);
    query(table_times[20] + 32'd12345);
    query(32'hffff_ffff);
    query(32'd1);
    // Zero-width first segment.
    load_entry(1, table_times[0], 32'h0000_1000);
    query(table_times[0] - 32'd7);
    query(table_times[0]);
    load_entry(1, (1 - 32) * (1 << 20), 32'h0001_2345);
    // Steep last segment, to saturate high.
    load_entry(62, 32'h7fff_0000, 32'h8000_0000);
    load_entry(63, 32'h7fff_0001, 32'h7fff_ffff);
    query(32'h7fff_ffff);
    query(32'h7fff_0000 + 32'd0);
    load_entry(63, 32'h7fff_0001, 32'h8000_0001);
    query(32'h7fff_ffff);
    write_point_count(7'd2);
    query(32'h8000_0000);
    query(32'h7fff_ffff);

    count_choices = '{2, 64, 0, 1, 127, 65, 3, 33};
    for (int phase = 0; phase < 12; phase++) begin
      write_point_count((phase < 8) ? 7'(count_choices[phase]) : 7'($urandom_range(63, 2)));
      n = (phase < 8) ? count_choices[phase] : int'(cfg_data);
      n = (n < 2) ? 2 : (n > 64) ? 64 : n;
      quiet = ($urandom_range(3) == 0);
      if (phase == 0 || $urandom_range(1)) fill_ascending();
      for (int i = 0; i < 120; i++) begin
        if ($urandom_range(9) == 0) begin
          load_entry($urandom_range(63), ($urandom_range(1)) ? $urandom :
                     table_times[$urandom_range(63)], $urandom);
        end else begin
          query(pick_query_time(n));
        end
      end
    end
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (200) @(posedge clk);
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
